FILE: design/bhu_pkg.sv
// Character codes and hex digit decode for the backslash/hex unescape decoder.
// No dependencies; used by backslash_hex_unescape_decoder.
package bhu_pkg;

    localparam int CODE_W = 16;

    localparam logic [CODE_W-1:0] CH_BSLASH = 16'h005C;
    localparam logic [CODE_W-1:0] CH_LOW_B  = 16'h0062;
    localparam logic [CODE_W-1:0] CH_LOW_N  = 16'h006E;
    localparam logic [CODE_W-1:0] CH_LOW_R  = 16'h0072;
    localparam logic [CODE_W-1:0] CH_LOW_T  = 16'h0074;
    localparam logic [CODE_W-1:0] CH_LOW_X  = 16'h0078;
    localparam logic [CODE_W-1:0] CH_LF     = 16'h000A;
    localparam logic [CODE_W-1:0] CH_BS     = 16'h0008;
    localparam logic [CODE_W-1:0] CH_CR     = 16'h000D;
    localparam logic [CODE_W-1:0] CH_TAB    = 16'h0009;
    localparam logic [CODE_W-1:0] CH_NUL    = 16'h0000;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } nibble_t;

    function automatic nibble_t hex_nibble(input logic [CODE_W-1:0] c);
        nibble_t r;
        r.ok  = 1'b1;
        r.val = 4'h0;
        if (c >= 16'h0030 && c <= 16'h0039) begin
            r.val = c[3:0];
        end else if ((c >= 16'h0061 && c <= 16'h0066) || (c >= 16'h0041 && c <= 16'h0046)) begin
            r.val = c[3:0] + 4'd9;
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

FILE: design/backslash_hex_unescape_decoder.sv
// Backslash escape decoder with fixed-length hex escapes, streaming in and out.
// Depends on bhu_pkg for character codes and the hex digit decode.
//
// channel | direction | tdata          | tlast    | tuser
// s_      | in        | code_in[15:0]  | end_in   | -
// m_      | out       | code_out[15:0] | run_last | is_terminator
//
// An item is decoded in the cycle it is accepted and its results are queued in a
// one-deep job register feeding the output register, one result per cycle while m_tready
// is high, so one-result items go at one per cycle. A bad hex escape plus end of string
// yields up to HEX_DIGITS+1 results; the input stalls until the job's last result moves.
// Reset is synchronous, active low; the raw digit store needs no reset.
module backslash_hex_unescape_decoder #(
    parameter int HEX_DIGITS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // code_in[15:0]
    input  logic        s_tlast,   // end_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // code_out[15:0]
    output logic        m_tlast,   // run_last
    output logic        m_tuser    // is_terminator
);

    localparam int STORE_DEPTH = HEX_DIGITS - 1;
    localparam int CNT_W = $clog2(HEX_DIGITS);
    localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int ACC_W = (4 * STORE_DEPTH < 12) ? 4 * STORE_DEPTH : 12;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_SLASH  = 2'd1,
        MODE_HEX    = 2'd2
    } mode_t;

    typedef struct packed {
        logic             head_vld;
        logic [15:0]      head;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] left;
        logic             term;
    } job_t;

    mode_t            mode_reg, mode_next;
    logic [CNT_W-1:0] digit_count_reg, digit_count_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [15:0]      store_reg [STORE_DEPTH];
    job_t             job_reg, job_next, job_new;
    logic             m_tvalid_reg;
    logic [15:0]      m_tdata_reg;
    logic             m_tlast_reg;
    logic             m_tuser_reg;

    logic               accept;
    logic               store_we;
    bhu_pkg::nibble_t   nib;
    logic [ACC_W+3:0]   hex_word;
    logic               job_busy;
    logic               job_last;
    logic               out_free;
    logic               pop;
    logic [15:0]        cur_code;
    logic               cur_term;

    assign nib      = bhu_pkg::hex_nibble(s_tdata);
    assign hex_word = {acc_reg, nib.val};

    always_comb begin
        mode_next        = mode_reg;
        digit_count_next = digit_count_reg;
        acc_next         = acc_reg;
        store_we         = 1'b0;
        job_new.head_vld = 1'b0;
        job_new.head     = s_tdata;
        job_new.idx      = '0;
        job_new.left     = '0;
        job_new.term     = 1'b0;
        unique case (mode_reg)
            MODE_SLASH: begin
                mode_next = MODE_NORMAL;
                unique case (s_tdata)
                    bhu_pkg::CH_LOW_B: begin
                        job_new.head_vld = 1'b1;
                        job_new.head     = bhu_pkg::CH_BS;
                    end
                    bhu_pkg::CH_LOW_N: begin
                        job_new.head_vld = 1'b1;
                        job_new.head     = bhu_pkg::CH_LF;
                    end
                    bhu_pkg::CH_LOW_R: begin
                        job_new.head_vld = 1'b1;
                        job_new.head     = bhu_pkg::CH_CR;
                    end
                    bhu_pkg::CH_LOW_T: begin
                        job_new.head_vld = 1'b1;
                        job_new.head     = bhu_pkg::CH_TAB;
                    end
                    bhu_pkg::CH_LOW_X: begin
                        digit_count_next = '0;
                        acc_next         = '0;
                        mode_next        = MODE_HEX;
                    end
                    bhu_pkg::CH_LF: begin
                    end
                    default: begin
                        job_new.head_vld = 1'b1;
                    end
                endcase
            end
            MODE_HEX: begin
                if (!nib.ok) begin
                    job_new.head_vld = 1'b1;
                    job_new.head     = bhu_pkg::CH_LOW_X;
                    job_new.left     = digit_count_reg;
                    mode_next        = MODE_NORMAL;
                end else if (digit_count_reg == CNT_W'(STORE_DEPTH)) begin
                    job_new.head_vld = 1'b1;
                    job_new.head     = 16'(hex_word);
                    mode_next        = MODE_NORMAL;
                end else begin
                    store_we         = 1'b1;
                    digit_count_next = digit_count_reg + CNT_W'(1);
                    acc_next         = hex_word[ACC_W-1:0];
                end
            end
            default: begin
                if (s_tdata == bhu_pkg::CH_BSLASH) begin
                    mode_next = MODE_SLASH;
                end else begin
                    job_new.head_vld = 1'b1;
                end
            end
        endcase
        if (s_tlast) begin
            job_new.term     = 1'b1;
            mode_next        = MODE_NORMAL;
            digit_count_next = '0;
            acc_next         = '0;
        end
    end

    assign job_busy = job_reg.head_vld || (job_reg.left != '0) || job_reg.term;
    assign job_last = job_reg.head_vld ? ((job_reg.left == '0) && !job_reg.term)
                    : (job_reg.left != '0) ? ((job_reg.left == CNT_W'(1)) && !job_reg.term)
                    : 1'b1;
    assign out_free = !m_tvalid_reg || m_tready;
    assign pop      = job_busy && out_free;
    assign s_tready = !job_busy || (out_free && job_last);
    assign accept   = s_tvalid && s_tready;

    assign cur_code = job_reg.head_vld ? job_reg.head
                    : (job_reg.left != '0) ? store_reg[job_reg.idx]
                    : bhu_pkg::CH_NUL;
    assign cur_term = !job_reg.head_vld && (job_reg.left == '0);

    always_comb begin
        job_next = job_reg;
        if (accept) begin
            job_next = job_new;
        end else if (pop) begin
            if (job_reg.head_vld) begin
                job_next.head_vld = 1'b0;
            end else if (job_reg.left != '0) begin
                job_next.left = job_reg.left - CNT_W'(1);
                job_next.idx  = job_reg.idx + IDX_W'(1);
            end else begin
                job_next.term = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_NORMAL;
            digit_count_reg <= '0;
            acc_reg         <= '0;
            job_reg         <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (accept) begin
                mode_reg        <= mode_next;
                digit_count_reg <= digit_count_next;
                acc_reg         <= acc_next;
            end
            job_reg <= job_next;
            if (pop) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        if (pop) begin
            m_tdata_reg <= cur_code;
            m_tlast_reg <= job_last;
            m_tuser_reg <= cur_term;
        end
        if (accept && store_we) begin
            store_reg[digit_count_reg[IDX_W-1:0]] <= s_tdata;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    a_term_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("terminator transfer without tlast");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tlast |=> (mode_reg == MODE_NORMAL) && (digit_count_reg == '0))
        else $error("state not cleared after end of string");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        digit_count_reg <= CNT_W'(STORE_DEPTH))
        else $error("digit count beyond store depth");

    a_replay_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (job_reg.left != '0) |->
            (32'(job_reg.left) + 32'(job_reg.idx) <= STORE_DEPTH))
        else $error("replay reads past buffered digits");

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for backslash_hex_unescape_decoder: random escape streams under backpressure.
// Depends on bhu_pkg and the decoder RTL; predicts every output transfer in-line.
module testbench;

    localparam int CODE_W = bhu_pkg::CODE_W;
    localparam int HEX_DIGITS = 4;
    localparam int DIGIT_STORE = HEX_DIGITS - 1;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_UNITS = 76;
    localparam int MAX_REPORTS = 10;

    typedef enum logic [1:0] {
        ESC_PLAIN = 2'd0,
        ESC_SEEN  = 2'd1,
        ESC_HEX   = 2'd2
    } esc_state_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              eos;
    } text_unit_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              term;
        logic              last;
    } decoded_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata = '0;
    logic              s_tlast = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [15:0]       m_tdata;
    logic              m_tlast;
    logic              m_tuser;

    text_unit_t        text_q[$];
    decoded_t          decoded_q[$];
    int                units_queued = 0;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                mismatches = 0;
    int                quiet_cycles = 0;
    decoded_t          want;

    esc_state_t        esc_state = ESC_PLAIN;
    int                digits_held = 0;
    logic [15:0]       hex_value = '0;
    logic [CODE_W-1:0] held_digits[DIGIT_STORE];

    backslash_hex_unescape_decoder #(.HEX_DIGITS(HEX_DIGITS)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // bit 4 set when c is a hex digit, value in the low nibble
    function automatic logic [4:0] hex_digit_of(input logic [CODE_W-1:0] c);
        if (c >= 16'h0030 && c <= 16'h0039) return {1'b1, c[3:0]};
        if (c >= 16'h0061 && c <= 16'h0066) return {1'b1, 4'(c - 16'h0057)};
        if (c >= 16'h0041 && c <= 16'h0046) return {1'b1, 4'(c - 16'h0037)};
        return 5'b0;
    endfunction

    task automatic decode_unit(input logic [CODE_W-1:0] c, input logic eos);
        decoded_t    out[$];
        logic [4:0]  dig;
        dig = hex_digit_of(c);
        case (esc_state)
            ESC_SEEN: begin
                esc_state = ESC_PLAIN;
                if (c == bhu_pkg::CH_LOW_B)
                    out.insert(out.size(), '{bhu_pkg::CH_BS, 1'b0, 1'b0});
                else if (c == bhu_pkg::CH_LOW_N)
                    out.insert(out.size(), '{bhu_pkg::CH_LF, 1'b0, 1'b0});
                else if (c == bhu_pkg::CH_LOW_R)
                    out.insert(out.size(), '{bhu_pkg::CH_CR, 1'b0, 1'b0});
                else if (c == bhu_pkg::CH_LOW_T)
                    out.insert(out.size(), '{bhu_pkg::CH_TAB, 1'b0, 1'b0});
                else if (c == bhu_pkg::CH_LOW_X) begin
                    digits_held = 0;
                    hex_value = '0;
                    esc_state = ESC_HEX;
                end else if (c != bhu_pkg::CH_LF) begin
                    out.insert(out.size(), '{c, 1'b0, 1'b0});
                end
            end
            ESC_HEX: begin
                if (!dig[4]) begin
                    out.insert(out.size(), '{bhu_pkg::CH_LOW_X, 1'b0, 1'b0});
                    for (int i = 0; i < digits_held; i++)
                        out.insert(out.size(), '{held_digits[i], 1'b0, 1'b0});
                    esc_state = ESC_PLAIN;
                end else if (digits_held >= DIGIT_STORE) begin
                    out.insert(out.size(), '{{hex_value[11:0], dig[3:0]}, 1'b0, 1'b0});
                    esc_state = ESC_PLAIN;
                end else begin
                    held_digits[digits_held] = c;
                    digits_held++;
                    hex_value = {hex_value[11:0], dig[3:0]};
                end
            end
            default: begin
                if (c == bhu_pkg::CH_BSLASH) esc_state = ESC_SEEN;
                else out.insert(out.size(), '{c, 1'b0, 1'b0});
            end
        endcase
        if (eos) begin
            out.insert(out.size(), '{bhu_pkg::CH_NUL, 1'b1, 1'b0});
            esc_state = ESC_PLAIN;
            digits_held = 0;
            hex_value = '0;
        end
        if (out.size() > 0) out[out.size()-1].last = 1'b1;
        foreach (out[i]) decoded_q.insert(decoded_q.size(), out[i]);
    endtask

    task automatic put(input logic [CODE_W-1:0] c, input logic eos);
        text_q.insert(text_q.size(), '{c, eos});
        units_queued++;
    endtask

    function automatic logic roll_eos();
        return $urandom_range(11) == 0;
    endfunction

    function automatic logic [CODE_W-1:0] rand_hex_char();
        int v;
        v = $urandom_range(15);
        if (v < 10) return CODE_W'(16'h0030 + v);
        if ($urandom_range(1)) return CODE_W'(16'h0057 + v);
        return CODE_W'(16'h0037 + v);
    endfunction

    function automatic logic [CODE_W-1:0] rand_non_hex();
        logic [CODE_W-1:0] c;
        logic [4:0]        h;
        do begin
            if ($urandom_range(1)) c = CODE_W'($urandom_range(16'hFFFF));
            else c = CODE_W'($urandom_range(16'h007E, 16'h0020));
            h = hex_digit_of(c);
        end while (h[4]);
        return c;
    endfunction

    task automatic add_sequence();
        int kind;
        int sel;
        int k;
        kind = $urandom_range(9);
        case (kind)
            0, 1: put(CODE_W'($urandom_range(16'hFFFF)), roll_eos());
            2: put(CODE_W'($urandom_range(16'h007E, 16'h0020)), roll_eos());
            3, 4: begin
                sel = $urandom_range(5);
                put(bhu_pkg::CH_BSLASH, roll_eos());
                case (sel)
                    0: put(bhu_pkg::CH_LOW_B, roll_eos());
                    1: put(bhu_pkg::CH_LOW_N, roll_eos());
                    2: put(bhu_pkg::CH_LOW_R, roll_eos());
                    3: put(bhu_pkg::CH_LOW_T, roll_eos());
                    4: put(bhu_pkg::CH_LF, roll_eos());
                    default: put(CODE_W'($urandom_range(16'hFFFF)), roll_eos());
                endcase
            end
            5, 6, 7: begin
                put(bhu_pkg::CH_BSLASH, 1'b0);
                put(bhu_pkg::CH_LOW_X, 1'b0);
                for (int i = 0; i < HEX_DIGITS; i++) put(rand_hex_char(), roll_eos());
            end
            8: begin
                k = $urandom_range(HEX_DIGITS - 1);
                put(bhu_pkg::CH_BSLASH, 1'b0);
                put(bhu_pkg::CH_LOW_X, 1'b0);
                for (int i = 0; i < k; i++) put(rand_hex_char(), 1'b0);
                put(rand_non_hex(), roll_eos());
            end
            default: begin
                k = $urandom_range(HEX_DIGITS - 1);
                put(bhu_pkg::CH_BSLASH, 1'b0);
                if (k > 0) put(bhu_pkg::CH_LOW_X, 1'b0);
                for (int i = 1; i < k; i++) put(rand_hex_char(), 1'b0);
                put(rand_hex_char(), 1'b1);
            end
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) decode_unit(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (text_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= text_q[0].code;
                    s_tlast  <= text_q[0].eos;
                    void'(text_q.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= $urandom_range(99) >= recv_stall_pct;
        if (aresetn && m_tvalid && m_tready) begin
            if (decoded_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected transfer: code %h term %b last %b",
                             m_tdata, m_tuser, m_tlast);
            end else begin
                want = decoded_q.pop_front();
                if (m_tdata !== want.code || m_tuser !== want.term || m_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: expected code %h term %b last %b, got %h %b %b",
                                 want.code, want.term, want.last, m_tdata, m_tuser, m_tlast);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("backslash_hex_unescape_decoder verification failed");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        put(16'h0000, 1'b0);
        put(16'hFFFF, 1'b1);
        put(bhu_pkg::CH_BSLASH, 1'b0); put(bhu_pkg::CH_LOW_B, 1'b0);
        put(bhu_pkg::CH_BSLASH, 1'b0); put(bhu_pkg::CH_LOW_N, 1'b0);
        put(bhu_pkg::CH_BSLASH, 1'b0); put(bhu_pkg::CH_LOW_R, 1'b0);
        put(bhu_pkg::CH_BSLASH, 1'b0); put(bhu_pkg::CH_LOW_T, 1'b0);
        put(bhu_pkg::CH_BSLASH, 1'b0); put(bhu_pkg::CH_LF, 1'b0);
        put(bhu_pkg::CH_BSLASH, 1'b0); put(16'hFFFF, 1'b0);
        put(bhu_pkg::CH_BSLASH, 1'b0); put(bhu_pkg::CH_LOW_X, 1'b0);
        put(16'h0046, 1'b0); put(16'h0066, 1'b0); put(16'h0030, 1'b0); put(16'h0039, 1'b0);
        // bad digit after a full store, ending the string: longest burst
        put(bhu_pkg::CH_BSLASH, 1'b0); put(bhu_pkg::CH_LOW_X, 1'b0);
        put(16'h0041, 1'b0); put(16'h0061, 1'b0); put(16'h0037, 1'b0); put(16'hFFFF, 1'b1);
        put(bhu_pkg::CH_BSLASH, 1'b1);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            units_queued = 0;
            while (units_queued < PHASE_UNITS) add_sequence();
            while (text_q.size() > 0) @(posedge aclk);
        end

        while (text_q.size() > 0 || s_tvalid || decoded_q.size() > 0) @(posedge aclk);
        repeat (HEX_DIGITS + 8) @(posedge aclk);

        if (mismatches == 0 && decoded_q.size() == 0) begin
            $display("backslash_hex_unescape_decoder verification clean");
        end else begin
            $display("backslash_hex_unescape_decoder verification failed");
        end
        $finish;
    end

endmodule
